// File: hdl/pn3_pkg.sv
// shared constants and the permutation rom for the 3d noise block
`default_nettype none

package pn3_pkg;

  localparam int unsigned COORD_W       = 32;
  localparam int unsigned NOISE_W       = 16;
  localparam int unsigned CELL_W        = 8;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

endpackage

`default_nettype wire

// File: hdl/pn3_if.sv
// valid/ready channel interfaces for coordinates in and noise out
`default_nettype none

interface pn3_coord_if;
  logic                                valid;
  logic                                ready;
  logic signed [pn3_pkg::COORD_W-1:0] coord_x;
  logic signed [pn3_pkg::COORD_W-1:0] coord_y;
  logic signed [pn3_pkg::COORD_W-1:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface pn3_noise_if;
  logic                         valid;
  logic                         ready;
  logic [pn3_pkg::NOISE_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

`default_nettype wire

// File: hdl/pn3_fade.sv
// four-stage quintic fade curve 6t^5-15t^4+10t^3 in fixed point
`default_nettype none

module pn3_fade #(
  parameter int unsigned FracBits = pn3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [FracBits-1:0] t_i,
  output logic      [FracBits:0]   fade_o
);

  localparam int unsigned F  = FracBits;
  localparam int unsigned PW = 2 * F + 8;
  localparam int unsigned CW = F + 5;

  localparam logic signed [CW-1:0] FIFTEEN = CW'(15) << F;
  localparam logic signed [CW-1:0] TEN     = CW'(10) << F;
  localparam logic signed [PW-1:0] HALF_S  = PW'(1) << (F - 1);
  localparam logic signed [PW-1:0] ONE_S   = PW'(1) << F;
  localparam logic [2*F+1:0]       HALF_U  = (2 * F + 2)'(1) << (F - 1);

  // stage 1: t*(6t-15) and t*t
  logic signed [CW-1:0] lin;
  logic signed [PW-1:0] pc_d, pc_q;
  logic [2*F-1:0]       pt2_d, pt2_q;
  logic [F-1:0]         t1_q;

  // stage 2: c and t2*t
  logic signed [PW-1:0] cw;
  logic signed [CW-1:0] c_d, c_q;
  logic [2*F+1:0]       t2w;
  logic [2*F:0]         t3p_d, t3p_q;

  // stage 3: t3*c
  logic [2*F+1:0]       t3w;
  logic signed [PW-1:0] fp_d, fp_q;

  // stage 4: round and clamp
  logic signed [PW-1:0] fw;
  logic [F:0]           f_d, f_q;

  always_comb begin
    lin   = $signed({4'b0, t_i, 1'b0}) + $signed({3'b0, t_i, 2'b0}) - FIFTEEN;
    pc_d  = PW'($signed({1'b0, t_i})) * PW'(lin);
    pt2_d = (2 * F)'(t_i) * (2 * F)'(t_i);

    cw    = (pc_q + HALF_S) >>> F;
    c_d   = cw[CW-1:0] + TEN;
    t2w   = ((2 * F + 2)'(pt2_q) + HALF_U) >> F;
    t3p_d = (2 * F + 1)'(t2w[F:0]) * (2 * F + 1)'(t1_q);

    t3w   = ((2 * F + 2)'(t3p_q) + HALF_U) >> F;
    fp_d  = PW'($signed({1'b0, t3w[F:0]})) * PW'(c_q);

    fw    = (fp_q + HALF_S) >>> F;
    if (fw < 0) begin
      f_d = '0;
    end else if (fw > ONE_S) begin
      f_d = ONE_S[F:0];
    end else begin
      f_d = fw[F:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q  <= pc_d;
      pt2_q <= pt2_d;
      t1_q  <= t_i;
      c_q   <= c_d;
      t3p_q <= t3p_d;
      fp_q  <= fp_d;
      f_q   <= f_d;
    end
  end

  assign fade_o = f_q;

endmodule

`default_nettype wire

// File: hdl/pn3_hash.sv
// three-stage chained permutation lookups for the eight cube corners
`default_nettype none

module pn3_hash (
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire logic [7:0] xi_i,
  input  wire logic [7:0] yi_i,
  input  wire logic [7:0] zi_i,
  output logic      [7:0] hash_o [8]
);

  logic [7:0] a_d [2];
  logic [7:0] a_q [2];
  logic [7:0] b_d [4];
  logic [7:0] b_q [4];
  logic [7:0] h_d [8];
  logic [7:0] h_q [8];
  logic [7:0] y1_q, z1_q, z2_q;

  // corner index: bit 0 x+1, bit 1 y+1, bit 2 z+1
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      a_d[i] = pn3_pkg::PERM[xi_i + 8'(i)];
    end
    for (int j = 0; j < 4; j++) begin
      b_d[j] = pn3_pkg::PERM[a_q[j % 2] + y1_q + 8'(j / 2)];
    end
    for (int k = 0; k < 8; k++) begin
      h_d[k] = pn3_pkg::PERM[b_q[k % 4] + z2_q + 8'(k / 4)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= a_d;
      y1_q <= yi_i;
      z1_q <= zi_i;
      b_q  <= b_d;
      z2_q <= z1_q;
      h_q  <= h_d;
    end
  end

  assign hash_o = h_q;

endmodule

`default_nettype wire

// File: hdl/perlin_noise_3d.sv
// top level: eight-stage improved perlin noise pipeline, one point per cycle while the output is not stalled
// throughput: one point per clock; all stages advance together, so the
// input is ready whenever the output register is empty or being taken
// reset: rst_ni clears only the stage valid bits; the rom is constant
// stages 1-3 hash, 1-4 fade, 4 gradients, 5-7 lerps in x/y/z, 8 output
`default_nettype none

module perlin_noise_3d #(
  parameter int unsigned FracBits = pn3_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pn3_coord_if.sink  coord_in,
  pn3_noise_if.source noise_out
);

  localparam int unsigned F   = FracBits;
  localparam int unsigned GW  = F + 3;      // gradient sum
  localparam int unsigned LW  = F + 4;      // lerped values
  localparam int unsigned PW  = 2 * F + 8;  // products
  localparam int unsigned OW  = F + 24;     // output scaling
  localparam int          SH  = int'(F) + 1 - int'(pn3_pkg::NOISE_W);
  localparam int unsigned SH_R = (SH > 0) ? SH : 0;
  localparam int unsigned SH_L = (SH < 0) ? -SH : 0;
  localparam logic [OW-1:0] RND = (SH > 0) ? (OW'(1) << (SH_R - 1)) : '0;
  localparam logic [OW-1:0] SAT = OW'((1 << pn3_pkg::NOISE_W) - 1);

  localparam logic signed [PW-1:0] HALF_P = PW'(1) << (F - 1);
  localparam logic signed [LW:0]   ONE_L  = (LW + 1)'(1) << F;
  localparam logic [F:0]           ONE_F  = (F + 1)'(1) << F;

  // gradient selector codes
  localparam logic [3:0] HC_P_Y   = 4'd8;   // at and above: p takes y
  localparam logic [3:0] HC_Q_Y   = 4'd4;   // below: q takes y
  localparam logic [3:0] HC_Q_X_A = 4'd12;
  localparam logic [3:0] HC_Q_X_B = 4'd14;

  function automatic logic signed [GW-1:0] grad_fn(
    input logic [3:0]        h,
    input logic signed [F:0] x,
    input logic signed [F:0] y,
    input logic signed [F:0] z
  );
    logic signed [F:0]    p;
    logic signed [F:0]    q;
    logic signed [GW-1:0] ps;
    logic signed [GW-1:0] qs;
    p  = (h < HC_P_Y) ? x : y;
    q  = (h < HC_Q_Y) ? y : ((h == HC_Q_X_A || h == HC_Q_X_B) ? x : z);
    ps = GW'(p);
    qs = GW'(q);
    if (h[0]) ps = -ps;
    if (h[1]) qs = -qs;
    return ps + qs;
  endfunction

  // a + round(w*(b-a)) finishing step
  function automatic logic signed [LW-1:0] lerp_fin(
    input logic signed [LW-1:0] a,
    input logic signed [PW-1:0] p
  );
    logic signed [PW-1:0] r;
    r = (p + HALF_P) >>> F;
    return a + r[LW-1:0];
  endfunction

  // pipeline control: whole pipe moves when output slot frees
  logic       en;
  logic [8:1] v_q;

  assign en             = !v_q[8] || noise_out.ready;
  assign coord_in.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[7:1], coord_in.valid};
    end
  end

  // fade and hash units, results land at stage 4 / stage 3
  logic [F:0] u4, v4, w4;
  logic [7:0] hash3 [8];

  pn3_fade #(.FracBits(F)) u_fade_x (
    .clk_i (clk_i), .en_i (en), .t_i (coord_in.coord_x[F-1:0]), .fade_o (u4)
  );
  pn3_fade #(.FracBits(F)) u_fade_y (
    .clk_i (clk_i), .en_i (en), .t_i (coord_in.coord_y[F-1:0]), .fade_o (v4)
  );
  pn3_fade #(.FracBits(F)) u_fade_z (
    .clk_i (clk_i), .en_i (en), .t_i (coord_in.coord_z[F-1:0]), .fade_o (w4)
  );

  pn3_hash u_hash (
    .clk_i  (clk_i),
    .en_i   (en),
    .xi_i   (coord_in.coord_x[F+7:F]),
    .yi_i   (coord_in.coord_y[F+7:F]),
    .zi_i   (coord_in.coord_z[F+7:F]),
    .hash_o (hash3)
  );

  // fractions delayed to line up with the hashes
  logic [F-1:0] fr_q [3][3];  // [stage][axis]

  // stage 4: corner gradients
  logic signed [GW-1:0] g_d [8];
  logic signed [GW-1:0] g_q [8];

  // stage 5: x lerp products
  logic signed [LW-1:0] a5_d [4];
  logic signed [LW-1:0] a5_q [4];
  logic signed [PW-1:0] p5_d [4];
  logic signed [PW-1:0] p5_q [4];
  logic [F:0]           v5_q, w5_q;

  // stage 6: y lerp products
  logic signed [LW-1:0] l6   [4];
  logic signed [LW-1:0] a6_d [2];
  logic signed [LW-1:0] a6_q [2];
  logic signed [PW-1:0] p6_d [2];
  logic signed [PW-1:0] p6_q [2];
  logic [F:0]           w6_q;

  // stage 7: z lerp product
  logic signed [LW-1:0] m7 [2];
  logic signed [LW-1:0] a7_q;
  logic signed [PW-1:0] p7_d, p7_q;

  // stage 8: output scaling
  logic signed [LW-1:0] r8;
  logic signed [LW:0]   s8;
  logic [OW-1:0]        sc8;
  logic [pn3_pkg::NOISE_W-1:0] out_d, out_q;

  always_comb begin
    // corner k: bit 0 picks x-1, bit 1 y-1, bit 2 z-1
    for (int k = 0; k < 8; k++) begin
      g_d[k] = grad_fn(hash3[k][3:0],
                       (k % 2 == 1) ? $signed({1'b1, fr_q[2][0]}) : $signed({1'b0, fr_q[2][0]}),
                       ((k / 2) % 2 == 1) ? $signed({1'b1, fr_q[2][1]})
                                          : $signed({1'b0, fr_q[2][1]}),
                       (k / 4 == 1) ? $signed({1'b1, fr_q[2][2]}) : $signed({1'b0, fr_q[2][2]}));
    end

    for (int j = 0; j < 4; j++) begin
      a5_d[j] = LW'(g_q[2*j]);
      p5_d[j] = PW'($signed({1'b0, u4})) * PW'(LW'(g_q[2*j+1]) - LW'(g_q[2*j]));
    end

    for (int j = 0; j < 4; j++) begin
      l6[j] = lerp_fin(a5_q[j], p5_q[j]);
    end
    for (int i = 0; i < 2; i++) begin
      a6_d[i] = l6[2*i];
      p6_d[i] = PW'($signed({1'b0, v5_q})) * PW'((LW + 1)'(l6[2*i+1]) - (LW + 1)'(l6[2*i]));
    end

    for (int i = 0; i < 2; i++) begin
      m7[i] = lerp_fin(a6_q[i], p6_q[i]);
    end
    p7_d = PW'($signed({1'b0, w6_q})) * PW'((LW + 1)'(m7[1]) - (LW + 1)'(m7[0]));

    // offset by one, halve into q0.16, saturate
    r8  = lerp_fin(a7_q, p7_q);
    s8  = (LW + 1)'(r8) + ONE_L;
    sc8 = ((OW'(unsigned'(s8)) + RND) >> SH_R) << SH_L;
    if (s8 <= 0) begin
      out_d = '0;
    end else if (sc8 > SAT) begin
      out_d = SAT[pn3_pkg::NOISE_W-1:0];
    end else begin
      out_d = sc8[pn3_pkg::NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fr_q[0][0] <= coord_in.coord_x[F-1:0];
      fr_q[0][1] <= coord_in.coord_y[F-1:0];
      fr_q[0][2] <= coord_in.coord_z[F-1:0];
      fr_q[1]    <= fr_q[0];
      fr_q[2]    <= fr_q[1];
      g_q        <= g_d;
      a5_q       <= a5_d;
      p5_q       <= p5_d;
      v5_q       <= v4;
      w5_q       <= w4;
      a6_q       <= a6_d;
      p6_q       <= p6_d;
      w6_q       <= w5_q;
      a7_q       <= m7[0];
      p7_q       <= p7_d;
      out_q      <= out_d;
    end
  end

  assign noise_out.valid       = v_q[8];
  assign noise_out.noise_value = out_q;

  // an accepted point enters stage 1 on the next edge
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coord_in.valid && coord_in.ready |=> v_q[1])
    else $error("accepted item missing from stage 1");

  // a stalled pipe keeps every valid bit in place
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("valid bits moved during stall");

  // fade weights stay within [0,1]
  a_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (u4 <= ONE_F && v4 <= ONE_F && w4 <= ONE_F))
    else $error("fade weight out of range");

  // an item taken at the output with nothing behind it leaves the slot empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[8] && noise_out.ready && !v_q[7] |=> !noise_out.valid)
    else $error("output item repeated");

endmodule

`default_nettype wire

// File: verif/tb.sv
// testbench for the 3d perlin noise pipeline: random and directed points, self-checking
`timescale 1ns / 100ps
`default_nettype none

module tb;

  localparam int FB = pn3_pkg::FRAC_BITS_DEF;
  localparam int NUM_RANDOM = 830;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  pn3_coord_if coord_ch ();
  pn3_noise_if noise_ch ();

  perlin_noise_3d #(.FracBits(FB)) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coord_in (coord_ch.sink),
    .noise_out(noise_ch.source)
  );

  // fixed-point noise predictor and queue of pending noise values
  class noise_board;
    logic [15:0] pending_noise[$];
    int          mismatches = 0;

    // round half up, scale back by FB fraction bits
    static function longint rnd(longint p);
      return (p + (64'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    static function longint fade(longint t);
      longint one, c, t2, t3, f;
      one = 64'sd1 <<< FB;
      c   = rnd(t * (6 * t - 15 * one)) + 10 * one;
      t2  = rnd(t * t);
      t3  = rnd(t2 * t);
      f   = rnd(t3 * c);
      if (f < 0) f = 0;
      if (f > one) f = one;
      return f;
    endfunction

    static function longint grad(logic [7:0] hv, longint x, longint y, longint z);
      logic [3:0] h;
      longint p, q;
      h = hv[3:0];
      p = (h < 8) ? x : y;
      q = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (h[0] ? -p : p) + (h[1] ? -q : q);
    endfunction

    static function longint mix(longint a, longint b, longint w);
      return a + rnd(w * (b - a));
    endfunction

    static function logic [7:0] hash3(logic [7:0] cx, logic [7:0] cy, logic [7:0] cz);
      logic [7:0] h;
      h = pn3_pkg::PERM[cx];
      h = pn3_pkg::PERM[8'(h + cy)];
      return pn3_pkg::PERM[8'(h + cz)];
    endfunction

    static function logic [15:0] noise_of(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      logic [7:0] xi, yi, zi, xn, yn, zn;
      longint one, xf, yf, zf, xg, yg, zg, u, v, w, a0, a1, b0, b1, m0, m1, s, res;
      one = 64'sd1 <<< FB;
      xi = px[FB +: 8]; yi = py[FB +: 8]; zi = pz[FB +: 8];
      xn = xi + 8'd1; yn = yi + 8'd1; zn = zi + 8'd1;
      xf = longint'(px[FB-1:0]); yf = longint'(py[FB-1:0]); zf = longint'(pz[FB-1:0]);
      xg = xf - one; yg = yf - one; zg = zf - one;
      u = fade(xf); v = fade(yf); w = fade(zf);
      a0 = mix(grad(hash3(xi, yi, zi), xf, yf, zf), grad(hash3(xn, yi, zi), xg, yf, zf), u);
      a1 = mix(grad(hash3(xi, yn, zi), xf, yg, zf), grad(hash3(xn, yn, zi), xg, yg, zf), u);
      m0 = mix(a0, a1, v);
      b0 = mix(grad(hash3(xi, yi, zn), xf, yf, zg), grad(hash3(xn, yi, zn), xg, yf, zg), u);
      b1 = mix(grad(hash3(xi, yn, zn), xf, yg, zg), grad(hash3(xn, yn, zn), xg, yg, zg), u);
      m1 = mix(b0, b1, v);
      s = mix(m0, m1, w) + one;
      if (s <= 0) return 16'd0;
      if (FB + 1 > 16) res = (s + (64'sd1 <<< (FB - 16))) >>> (FB + 1 - 16);
      else res = s <<< (16 - FB - 1);
      if (res > 65535) res = 65535;
      return 16'(res);
    endfunction

    function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      pending_noise.push_back(noise_of(px, py, pz));
    endfunction

    function void check_noise(logic [15:0] got);
      logic [15:0] want;
      if (pending_noise.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected noise item %0d", got);
        return;
      end
      want = pending_noise.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("noise_value: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  noise_board board = new();

  // short gaps mostly, occasionally a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // stretches with no idling on either side
  logic burst_mode = 1'b0;

  initial begin
    coord_ch.valid   = 1'b0;
    coord_ch.coord_x = '0;
    coord_ch.coord_y = '0;
    coord_ch.coord_z = '0;
    noise_ch.ready   = 1'b0;
  end

  // offer one point and hold it until the pipeline takes it
  // valid stays high after the handshake so back-to-back points need no gap
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int g;
    g = burst_mode ? 0 : gap_len();
    if (g > 0) begin
      coord_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    coord_ch.valid   <= 1'b1;
    coord_ch.coord_x <= px;
    coord_ch.coord_y <= py;
    coord_ch.coord_z <= pz;
    do @(posedge clk_i); while (!coord_ch.ready);
    board.note_point(px, py, pz);
  endtask

  // random coordinate, biased toward cell edges, fraction extremes, cell 255 and near-half fractions
  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom();
    case ($urandom_range(0, 7))
      0: c[FB-1:0] = '0;
      1: c[FB-1:0] = '1;
      2: c[FB +: 8] = 8'hff;
      3: c[FB-1:0] = FB'((1 << (FB - 1)) + $urandom_range(0, 3) - 2);
      default: ;
    endcase
    return c;
  endfunction

  // receiver: random stalls, checks every noise item taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (noise_ch.valid && noise_ch.ready) board.check_noise(noise_ch.noise_value);
      noise_ch.ready <= burst_mode ? 1'b1 : ($urandom_range(0, 99) < 70);
    end
  end

  // burst stretches toggle now and then
  always @(posedge clk_i) if ($urandom_range(0, 199) == 0) burst_mode <= ~burst_mode;

  initial begin
    logic [31:0] dir_pts[$];
    int i;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, extremes, fraction extremes, cell wrap, half points
    dir_pts = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0000ffff,
                32'h00ff0000, 32'h00ffffff, 32'h00008000, 32'hffff0000, 32'h00010000,
                32'h55555555, 32'haaaaaaaa, 32'h00ff8000, 32'h12344000, 32'hfffe0001};
    foreach (dir_pts[k]) send_point(dir_pts[k], dir_pts[k], dir_pts[k]);
    send_point(32'h0, 32'hffffffff, 32'h7fffffff);
    send_point(32'h00ffffff, 32'h0, 32'h00ff0000);
    send_point(32'h00008000, 32'h00ffc000, 32'h00004000);
    send_point(32'h80000001, 32'h00000001, 32'h7ffe0000);

    // hold off until the pipeline has drained
    coord_ch.valid <= 1'b0;
    while (board.pending_noise.size() != 0) @(posedge clk_i);

    for (i = 0; i < NUM_RANDOM; i++) begin
      send_point(rand_coord(), rand_coord(), rand_coord());
      if (i == NUM_RANDOM / 2) begin
        coord_ch.valid <= 1'b0;
        while (board.pending_noise.size() != 0) @(posedge clk_i);
      end
    end
    coord_ch.valid <= 1'b0;

    i = 0;
    while (board.pending_noise.size() != 0 && i < 20000) begin
      @(posedge clk_i);
      i++;
    end
    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_noise.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hdl/pn3_pkg.sv
hdl/pn3_if.sv
hdl/pn3_fade.sv
hdl/pn3_hash.sv
hdl/perlin_noise_3d.sv
verif/tb.sv
